// ===== hw/rtl/fpra_pkg.sv =====
// ----------------------------------------------------------------------------
// fpra_pkg
// Shared types and format conversions for the half precision reduce adder.
// ----------------------------------------------------------------------------
package fpra_pkg;

   localparam int unsigned NUM_STAGES = 7;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_PAIR  = 2'd0;
   localparam mode_type MODE_RES2  = 2'd1;
   localparam mode_type MODE_RES3  = 2'd2;
   localparam mode_type MODE_RES4  = 2'd3;

   typedef struct packed {
      mode_type    mode;
      logic        last;
      logic [31:0] h;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } item_type;

   // binary16 -> binary32, exact; NaNs are quieted
   function automatic logic [31:0] widen_half(input logic [15:0] hv);
      logic       s;
      logic [4:0] e;
      logic [9:0] m;
      logic [3:0] pos;
      logic [3:0] k;
      logic [9:0] mn;
      logic [31:0] r;
      s   = hv[15];
      e   = hv[14:10];
      m   = hv[9:0];
      pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) pos = 4'(i);
      end
      k  = 4'd10 - pos;
      mn = m << k;
      if (e == 5'd31) begin
         r = (m != 10'd0) ? {s, 8'hFF, 1'b1, m[8:0], 13'd0} : {s, 8'hFF, 23'd0};
      end else if (e == 5'd0) begin
         if (m == 10'd0) r = {s, 31'd0};
         else r = {s, 8'(8'd113 - 8'(k)), mn, 13'd0};
      end else begin
         r = {s, 8'(8'(e) + 8'd112), m, 13'd0};
      end
      return r;
   endfunction

   // binary32 -> binary16, round nearest even, overflow to infinity
   function automatic logic [15:0] narrow_single(input logic [31:0] xv);
      logic               s;
      logic [7:0]         e;
      logic [23:0]        m;
      logic signed [9:0]  eh;
      logic [7:0]         sh;
      logic [31:0]        q;
      logic [31:0]        rem;
      logic [31:0]        half;
      logic [31:0]        bits;
      logic [15:0]        r;
      s  = xv[31];
      e  = xv[30:23];
      m  = {1'b0, xv[22:0]};
      if (e == 8'd0) e = 8'd1;
      else m[23] = 1'b1;
      eh = $signed({2'b00, e}) - 10'sd112;
      sh = 8'd13;
      if (eh < 10'sd1) begin
         sh = 8'(10'sd14 - eh);
         eh = 10'sd1;
      end
      if (sh >= 8'd25) begin
         q = 32'd0;
      end else begin
         q    = {8'd0, m} >> sh;
         rem  = {8'd0, m} & ((32'd1 << sh) - 32'd1);
         half = 32'd1 << (sh - 8'd1);
         if (rem > half || (rem == half && q[0])) q = q + 32'd1;
      end
      bits = (32'($unsigned(eh - 10'sd1)) << 10) + q;
      if (xv[30:23] == 8'hFF) begin
         r = (xv[22:0] != 23'd0) ? {s, 6'b111111, xv[21:13]} : {s, 15'h7C00};
      end else if (bits >= 32'h7C00) begin
         r = {s, 15'h7C00};
      end else begin
         r = {s, bits[14:0]};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/fpra_add.sv =====
// ----------------------------------------------------------------------------
// fpra_add
// Two stage binary32 adder, round nearest even: align and add, then
// normalize and round.
// ----------------------------------------------------------------------------
module fpra_add (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] op_x,
   input  logic [31:0] op_y,
   output logic [31:0] sum
);
   logic [7:0]  ex, ey, eb, es, d;
   logic [22:0] mx, my;
   logic        sx, sy, sb, ss, swap;
   logic [23:0] ma, mb;
   logic [26:0] fa, fb, fbs;
   logic [27:0] raw;
   logic        rsign;
   logic        spec;
   logic [31:0] spec_val;

   logic        spec_ff;
   logic [31:0] spec_val_ff;
   logic [27:0] raw_ff;
   logic [7:0]  e_ff;
   logic        sign_ff;

   always_comb begin
      ex = op_x[30:23];
      ey = op_y[30:23];
      mx = op_x[22:0];
      my = op_y[22:0];
      sx = op_x[31];
      sy = op_y[31];
      spec = 1'b1;
      if (ex == 8'hFF && mx != 23'd0) spec_val = op_x | 32'h0040_0000;
      else if (ey == 8'hFF && my != 23'd0) spec_val = op_y | 32'h0040_0000;
      else if (ex == 8'hFF) spec_val = (ey == 8'hFF && sx != sy) ? 32'hFFC0_0000 : op_x;
      else if (ey == 8'hFF) spec_val = op_y;
      else begin
         spec_val = 32'd0;
         spec = 1'b0;
      end
      ma = {ex != 8'd0, mx};
      mb = {ey != 8'd0, my};
      if (ex == 8'd0) ex = 8'd1;
      if (ey == 8'd0) ey = 8'd1;
      swap = ex < ey;
      es = swap ? ey : ex;
      eb = swap ? ex : ey;
      ss = swap ? sy : sx;
      sb = swap ? sx : sy;
      fa = swap ? {mb, 3'b000} : {ma, 3'b000};
      fb = swap ? {ma, 3'b000} : {mb, 3'b000};
      d  = es - eb;
      if (d >= 8'd27) begin
         fbs = {26'd0, fb != 27'd0};
      end else begin
         fbs = fb >> d;
         fbs[0] = fbs[0] | ((fbs << d) != fb);
      end
      if (ss == sb) begin
         raw   = {1'b0, fa} + {1'b0, fbs};
         rsign = ss;
      end else if (fa >= fbs) begin
         raw   = {1'b0, fa} - {1'b0, fbs};
         rsign = (raw == 28'd0) ? 1'b0 : ss;
      end else begin
         raw   = {1'b0, fbs} - {1'b0, fa};
         rsign = sb;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spec_ff     <= spec;
         spec_val_ff <= spec_val;
         raw_ff      <= raw;
         e_ff        <= es;
         sign_ff     <= rsign;
      end
   end

   logic [4:0]        p;
   logic signed [9:0] ebig;
   logic signed [5:0] shift;
   logic [31:0]       q, rem, half, bits;
   logic [31:0]       res;

   always_comb begin
      p = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (raw_ff[i]) p = 5'(i);
      end
      ebig  = $signed({2'b00, e_ff}) + $signed({5'd0, p}) - 10'sd26;
      shift = $signed({1'b0, p}) - 6'sd23;
      if (ebig < 10'sd1) begin
         shift = shift + 6'(10'sd1 - ebig);
         ebig  = 10'sd1;
      end
      if (shift <= 6'sd0) begin
         q = {4'd0, raw_ff} << 6'(-shift);
      end else begin
         q    = {4'd0, raw_ff} >> shift;
         rem  = {4'd0, raw_ff} & ((32'd1 << shift) - 32'd1);
         half = 32'd1 << (shift - 6'sd1);
         if (rem > half || (rem == half && q[0])) q = q + 32'd1;
      end
      rem  = 32'd0;
      half = 32'd0;
      bits = (32'($unsigned(ebig - 10'sd1)) << 23) + q;
      if (spec_ff) res = spec_val_ff;
      else if (raw_ff == 28'd0) res = {sign_ff, 31'd0};
      else if (bits >= 32'h7F80_0000) res = {sign_ff, 31'h7F80_0000};
      else res = {sign_ff, bits[30:0]};
   end

   assign sum = res;

endmodule

// ===== hw/rtl/fp16_multi_operand_reduce_add.sv =====
// ----------------------------------------------------------------------------
// fp16_multi_operand_reduce_add
// Sums up to four binary16 partials, plus a binary16 residual outside pair mode,
// in binary32, then rounds the sum to binary16.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer in and one out per cycle while no response
// waits. A widening stage feeds three levels of two stage binary32 adders,
// which feed a narrowing output register. The whole pipeline holds while a
// response waits; mode is sampled with each item.
module fp16_multi_operand_reduce_add (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  fpra_pkg::mode_type      csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [15:0]             req_residual,
   input  logic [15:0]             req_part_a,
   input  logic [15:0]             req_part_b,
   input  logic [15:0]             req_part_c,
   input  logic [15:0]             req_part_d,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_total,
   output logic                    rsp_last_out
);
   import fpra_pkg::*;

   mode_type                  mode_ff;
   logic                      en;
   logic [NUM_STAGES:0]       vld_ff;
   item_type                  st_ff [NUM_STAGES];
   item_type                  st_in [NUM_STAGES];
   logic [31:0]               sum_ha, sum_bc, sum_bcd, sum_fin;
   logic [31:0]               fin_l, fin_r;
   logic [15:0]               total_ff;
   logic                      last_ff;

   assign en        = !vld_ff[NUM_STAGES] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PAIR;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   fpra_add u_add_ha  (.clock, .en, .op_x(st_ff[0].h), .op_y(st_ff[0].a), .sum(sum_ha));
   fpra_add u_add_bc  (.clock, .en, .op_x(st_ff[0].b), .op_y(st_ff[0].c), .sum(sum_bc));
   fpra_add u_add_bcd (.clock, .en, .op_x(st_ff[2].y), .op_y(st_ff[2].d), .sum(sum_bcd));
   fpra_add u_add_fin (.clock, .en, .op_x(fin_l), .op_y(fin_r), .sum(sum_fin));

   always_comb begin
      st_in[0].mode = mode_ff;
      st_in[0].last = req_last_in;
      st_in[0].h    = widen_half(req_residual);
      st_in[0].a    = widen_half(req_part_a);
      st_in[0].b    = widen_half(req_part_b);
      st_in[0].c    = widen_half(req_part_c);
      st_in[0].d    = widen_half(req_part_d);
      st_in[0].x    = 32'd0;
      st_in[0].y    = 32'd0;
      st_in[0].z    = 32'd0;
      for (int i = 1; i < NUM_STAGES; i++) begin
         st_in[i] = st_ff[i-1];
      end
      st_in[2].x = sum_ha;
      st_in[2].y = sum_bc;
      st_in[4].z = (st_ff[3].mode == MODE_RES4) ? sum_bcd : st_ff[3].y;
      st_in[6].x = sum_fin;
   end

   always_comb begin
      fin_l = (st_ff[4].mode == MODE_PAIR) ? st_ff[4].a : st_ff[4].x;
      case (st_ff[4].mode)
         MODE_PAIR: fin_r = st_ff[4].b;
         MODE_RES2: fin_r = st_ff[4].b;
         MODE_RES3: fin_r = st_ff[4].y;
         MODE_RES4: fin_r = st_ff[4].z;
         default:   fin_r = st_ff[4].z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_STAGES-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            st_ff[i] <= st_in[i];
         end
         total_ff <= narrow_single(st_ff[NUM_STAGES-1].x);
         last_ff  <= st_ff[NUM_STAGES-1].last;
      end
   end

   assign rsp_valid    = vld_ff[NUM_STAGES];
   assign rsp_total    = total_ff;
   assign rsp_last_out = last_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid chain moved during stall");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[NUM_STAGES-1] |=> rsp_valid)
      else $error("item lost before output register");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer not captured");

endmodule

// ===== sim/fp16_multi_operand_reduce_add_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp16_multi_operand_reduce_add_tb
// Self-checking bench for the half precision reduce adder. A directed table of
// corner operands is followed by random traffic in every mode; results are
// compared with a local binary32/binary16 arithmetic predictor.
// ----------------------------------------------------------------------------
module fp16_multi_operand_reduce_add_tb;
   import fpra_pkg::*;

   typedef struct {
      logic [15:0] res;
      logic [15:0] pa;
      logic [15:0] pb;
      logic [15:0] pc;
      logic [15:0] pd;
      logic        last;
   } operands_type;

   typedef struct {
      logic [15:0] total;
      logic        last;
   } sum_type;

   typedef struct {
      mode_type     mode;
      operands_type ops;
      logic         known;
      logic [15:0]  total;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   mode_type    csr_wr_data = MODE_PAIR;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_residual = '0;
   logic [15:0] req_part_a = '0;
   logic [15:0] req_part_b = '0;
   logic [15:0] req_part_c = '0;
   logic [15:0] req_part_d = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_total;
   logic        rsp_last_out;

   mode_type    cur_mode = MODE_PAIR;
   sum_type     pending_sums[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_recv = 0;
   bit          quiet_tail = 1'b0;
   bit          hold_rsp = 1'b0;
   bit          modes_seen[4];

   always #6 clock = ~clock;

   fp16_multi_operand_reduce_add i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_residual(req_residual), .req_part_a(req_part_a),
      .req_part_b(req_part_b), .req_part_c(req_part_c),
      .req_part_d(req_part_d), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_total(rsp_total), .rsp_last_out(rsp_last_out)
   );

   function automatic logic [31:0] half_to_single(input logic [15:0] hv);
      logic [4:0]  e;
      logic [9:0]  m;
      int          k;
      e = hv[14:10];
      m = hv[9:0];
      k = 0;
      if (e == 5'd31)
         return (m != 0) ? {hv[15], 8'hFF, 1'b1, m[8:0], 13'd0} : {hv[15], 8'hFF, 23'd0};
      if (e == 5'd0) begin
         if (m == 0) return {hv[15], 31'd0};
         while (!m[9]) begin
            m = m << 1;
            k++;
         end
         return {hv[15], 8'(112 - k), m[8:0], 14'd0};
      end
      return {hv[15], 8'(e + 112), m, 13'd0};
   endfunction

   function automatic logic [31:0] single_add(input logic [31:0] x, input logic [31:0] y);
      logic [7:0]  ex, ey, et;
      logic [23:0] mx, my;
      logic        sx, sy, st, sgn;
      logic [63:0] a, b, t, sm, q, rem, hf;
      int          d, p, eb, sh;
      logic [31:0] bits;
      ex = x[30:23]; ey = y[30:23];
      mx = {1'b0, x[22:0]}; my = {1'b0, y[22:0]};
      sx = x[31]; sy = y[31];
      if (ex == 8'hFF && mx != 0) return x | 32'h0040_0000;
      if (ey == 8'hFF && my != 0) return y | 32'h0040_0000;
      if (ex == 8'hFF) begin
         if (ey == 8'hFF && sx != sy) return 32'hFFC0_0000;
         return x;
      end
      if (ey == 8'hFF) return y;
      if (ex == 0) ex = 1; else mx[23] = 1'b1;
      if (ey == 0) ey = 1; else my[23] = 1'b1;
      a = {8'd0, mx, 32'd0};
      b = {8'd0, my, 32'd0};
      if (ex < ey) begin
         t = a; a = b; b = t;
         et = ex; ex = ey; ey = et;
         st = sx; sx = sy; sy = st;
      end
      d = ex - ey;
      if (d >= 56) b = (b != 0) ? 64'd1 : 64'd0;
      else if (d > 0) b = (b >> d) | (((b & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
      if (sx == sy) begin
         sm = a + b;
         sgn = sx;
         if (sm == 0) return {sgn, 31'd0};
      end else if (a >= b) begin
         sm = a - b;
         sgn = sx;
         if (sm == 0) return 32'd0;
      end else begin
         sm = b - a;
         sgn = sy;
      end
      p = 63;
      while (!sm[p]) p--;
      eb = int'(ex) + p - 55;
      sh = p - 23;
      if (eb < 1) begin
         sh += 1 - eb;
         eb = 1;
      end
      if (sh <= 0) q = sm << (-sh);
      else if (sh >= 64) q = 0;
      else begin
         q = sm >> sh;
         rem = sm & ((64'd1 << sh) - 1);
         hf = 64'd1 << (sh - 1);
         if (rem > hf || (rem == hf && q[0])) q++;
      end
      bits = (32'(eb - 1) << 23) + q[31:0];
      if (bits >= 32'h7F80_0000) return {sgn, 31'h7F80_0000};
      return {sgn, bits[30:0]};
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] x);
      int          e, eh, sh;
      logic [31:0] m, q, rem, hf, bits;
      e = x[30:23];
      m = {9'd0, x[22:0]};
      if (e == 255)
         return (m != 0) ? {x[31], 6'b111111, x[21:13]} : {x[31], 15'h7C00};
      if (e == 0) e = 1; else m[23] = 1'b1;
      eh = e - 112;
      sh = 13;
      if (eh < 1) begin
         sh += 1 - eh;
         eh = 1;
      end
      if (sh >= 32) q = 0;
      else begin
         q = m >> sh;
         rem = m & ((32'd1 << sh) - 1);
         hf = 32'd1 << (sh - 1);
         if (rem > hf || (rem == hf && q[0])) q++;
      end
      bits = (32'(eh - 1) << 10) + q;
      if (bits >= 32'h7C00) return {x[31], 15'h7C00};
      return {x[31], bits[14:0]};
   endfunction

   function automatic logic [15:0] reduce_sum(input mode_type md, input operands_type op);
      logic [31:0] h, a, b, c, d, s;
      h = half_to_single(op.res); a = half_to_single(op.pa);
      b = half_to_single(op.pb); c = half_to_single(op.pc);
      d = half_to_single(op.pd);
      case (md)
         MODE_PAIR: s = single_add(a, b);
         MODE_RES2: s = single_add(single_add(h, a), b);
         MODE_RES3: s = single_add(single_add(h, a), single_add(b, c));
         default:   s = single_add(single_add(h, a), single_add(single_add(b, c), d));
      endcase
      return single_to_half(s);
   endfunction

   function automatic logic [15:0] rand_half();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 9))
         0: v[14:10] = 5'd31;
         1: v[14:10] = 5'd0;
         2: v[14:10] = 5'($urandom_range(13, 17));
         3: v[14:10] = 5'($urandom_range(27, 30));
         default: ;
      endcase
      return v;
   endfunction

   task automatic send(input operands_type op, input logic chk, input logic [15:0] want);
      sum_type     s;
      logic [15:0] pred;
      req_valid    <= 1'b1;
      req_residual <= op.res;
      req_part_a   <= op.pa;
      req_part_b   <= op.pb;
      req_part_c   <= op.pc;
      req_part_d   <= op.pd;
      req_last_in  <= op.last;
      do @(posedge clock); while (!req_ready);
      pred = reduce_sum(cur_mode, op);
      if (chk && pred !== want) begin
         $error("table total mismatch: expected %h predicted %h", want, pred);
         errors++;
      end
      s.total = chk ? want : pred;
      s.last  = op.last;
      pending_sums.push_back(s);
      n_sent++;
      modes_seen[cur_mode] = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_mode(input mode_type md);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= md;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = md;
   endtask

   // response side: random stalls, plus one long hold while traffic continues
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (40) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      sum_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         n_recv++;
         if (pending_sums.size() == 0) begin
            $error("unexpected transfer: total %h", rsp_total);
            errors++;
         end else begin
            w = pending_sums.pop_front();
            if (rsp_total !== w.total) begin
               $error("total: expected %h actual %h", w.total, rsp_total);
               errors++;
            end
            if (rsp_last_out !== w.last) begin
               $error("last_out: expected %b actual %b", w.last, rsp_last_out);
               errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      vector_type   tbl[$];
      vector_type   v;
      operands_type op;
      mode_type     md;
      int           n;

      // mode, {res, a, b, c, d, last}, known, total
      tbl.push_back('{MODE_PAIR, '{16'h1234, 16'h0000, 16'h0000, 16'h0, 16'h0, 1'b0}, 1, 16'h0000});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h8000, 16'h8000, 16'h0, 16'h0, 1'b1}, 1, 16'h8000});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h3C00, 16'hBC00, 16'h0, 16'h0, 1'b0}, 1, 16'h0000});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h7BFF, 16'h7BFF, 16'h0, 16'h0, 1'b1}, 1, 16'h7C00});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'hFBFF, 16'hFBFF, 16'h0, 16'h0, 1'b0}, 1, 16'hFC00});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h7C00, 16'hFC00, 16'h0, 16'h0, 1'b0}, 1, 16'hFE00});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h7D23, 16'h3C00, 16'h0, 16'h0, 1'b0}, 1, 16'h7F23});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h3C00, 16'hFC01, 16'h0, 16'h0, 1'b1}, 1, 16'hFE01});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'h0001, 16'h0001, 16'h0, 16'h0, 1'b0}, 1, 16'h0002});
      tbl.push_back('{MODE_PAIR, '{16'hFFFF, 16'h03FF, 16'h0001, 16'h0, 16'h0, 1'b0}, 0, 16'h0});
      tbl.push_back('{MODE_PAIR, '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0, 1'b1}, 0, 16'h0});
      tbl.push_back('{MODE_RES2, '{16'h3C00, 16'h3C00, 16'h3C00, 16'hFFFF, 16'hFFFF, 1'b0}, 1, 16'h4200});
      tbl.push_back('{MODE_RES2, '{16'h7C00, 16'h0000, 16'hFC00, 16'h0, 16'h0, 1'b1}, 1, 16'hFE00});
      tbl.push_back('{MODE_RES2, '{16'h7BFF, 16'h7BFF, 16'hFBFF, 16'h0, 16'h0, 1'b0}, 0, 16'h0});
      tbl.push_back('{MODE_RES2, '{16'h0400, 16'h8001, 16'h1400, 16'h0, 16'h0, 1'b0}, 0, 16'h0});
      tbl.push_back('{MODE_RES3, '{16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00, 16'hFFFF, 1'b1}, 1, 16'h4400});
      tbl.push_back('{MODE_RES3, '{16'h0000, 16'h0000, 16'h7E00, 16'h7D00, 16'h0, 1'b0}, 1, 16'h7E00});
      tbl.push_back('{MODE_RES3, '{16'h5BFF, 16'h1001, 16'hDBFF, 16'h9001, 16'h0, 1'b0}, 0, 16'h0});
      tbl.push_back('{MODE_RES4, '{16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00, 1'b1}, 1, 16'h4500});
      tbl.push_back('{MODE_RES4, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1, 16'hFFFF});
      tbl.push_back('{MODE_RES4, '{16'h6800, 16'h0001, 16'h8001, 16'hE800, 16'h0001, 1'b0}, 0, 16'h0});
      tbl.push_back('{MODE_RES4, '{16'h7BFF, 16'h7BFF, 16'hFC00, 16'h7C00, 16'h0, 1'b1}, 0, 16'h0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (tbl[i]) begin
         if (tbl[i].mode != cur_mode) set_mode(tbl[i].mode);
         send(tbl[i].ops, tbl[i].known, tbl[i].total);
      end

      // random phases through every mode, low and high ends included
      for (int ph = 0; ph < 8; ph++) begin
         md = (ph < 4) ? mode_type'(ph) : mode_type'($urandom_range(0, 3));
         if (ph == 7) md = MODE_RES4;
         set_mode(md);
         if (ph == 2) hold_rsp = 1'b1;
         if (ph == 7) quiet_tail = 1'b1;
         n = 54;
         for (int k = 0; k < n; k++) begin
            op.res = rand_half(); op.pa = rand_half(); op.pb = rand_half();
            op.pc = rand_half(); op.pd = rand_half(); op.last = 1'($urandom);
            if (k == 20 && !quiet_tail) begin
               req_valid <= 1'b0;
               while (pending_sums.size() != 0) @(posedge clock);
            end
            send(op, 1'b0, 16'h0);
         end
      end
      drain();

      $display("covered %0d transfers in, %0d out; modes hit %b%b%b%b, long hold on response",
               n_sent, n_recv, modes_seen[3], modes_seen[2], modes_seen[1], modes_seen[0]);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/fpra_pkg.sv
hw/rtl/fpra_add.sv
hw/rtl/fp16_multi_operand_reduce_add.sv
sim/fp16_multi_operand_reduce_add_tb.sv
